[sv/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the toroidal life grid block.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int ROW_W     = 64;
  localparam int SEL_W     = 6;
  localparam int COLS_W    = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int NBR_W     = 4;

  localparam logic [CFG_W-1:0] GRID_DIM_RESET = 7'd64;

  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

  typedef struct packed {
    logic shift;
    logic run;
    logic wr;
  } lgs_cell_ctrl_t;

endpackage

[sv/lgs_in_if.sv]
// ----------------------------------------------------------------------------
// lgs_in_if
// Request channel: row write or generation step.
// ----------------------------------------------------------------------------
interface lgs_in_if import lgs_pkg::*;;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [SEL_W-1:0] row_select;
  logic [ROW_W-1:0] row_cells;

  modport source (output valid, operation, row_select, row_cells, input ready);
  modport sink   (input valid, operation, row_select, row_cells, output ready);
endinterface

[sv/lgs_out_if.sv]
// ----------------------------------------------------------------------------
// lgs_out_if
// Result channel: one new row of a generation per transfer.
// ----------------------------------------------------------------------------
interface lgs_out_if import lgs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] out_row;
  logic [ROW_W-1:0] out_cells;
  logic             last_row;

  modport source (output valid, out_row, out_cells, last_row, input ready);
  modport sink   (input valid, out_row, out_cells, last_row, output ready);
endinterface

[sv/lgs_cfg_if.sv]
// ----------------------------------------------------------------------------
// lgs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lgs_cfg_if import lgs_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/lgs_rule.sv]
// ----------------------------------------------------------------------------
// lgs_rule
// B3/S23 update of one row from its upper, own and lower row words, with
// column wraparound at the columns in use.
// ----------------------------------------------------------------------------
module lgs_rule import lgs_pkg::*; #(
  parameter int W = MAX_COLS_DEF
) (
  input  logic [W-1:0]      up_row,
  input  logic [W-1:0]      mid_row,
  input  logic [W-1:0]      down_row,
  input  logic [W-1:0]      col_mask,
  input  logic [COLS_W-1:0] cols_used,
  output logic [W-1:0]      new_row
);

  logic [W-1:0]     up_m, mid_m, dn_m;
  logic [W-1:0]     wrap_sel;
  logic [W:0]       up_l, mid_l, dn_l;
  logic [W:0]       up_r, mid_r, dn_r;
  logic [W-1:0]     up_lc, mid_lc, dn_lc;
  logic [W-1:0]     up_rc, mid_rc, dn_rc;
  logic [NBR_W-1:0] nbr [W];

  always_comb begin
    up_m     = up_row & col_mask;
    mid_m    = mid_row & col_mask;
    dn_m     = down_row & col_mask;
    wrap_sel = W'(1) << (cols_used - COLS_W'(1));
    up_l     = {up_m, |(up_m & wrap_sel)};
    mid_l    = {mid_m, |(mid_m & wrap_sel)};
    dn_l     = {dn_m, |(dn_m & wrap_sel)};
    up_r     = {up_m[0], up_m};
    mid_r    = {mid_m[0], mid_m};
    dn_r     = {dn_m[0], dn_m};
    for (int c = 0; c < W; c++) begin
      up_lc[c]  = up_l[c];
      mid_lc[c] = mid_l[c];
      dn_lc[c]  = dn_l[c];
      up_rc[c]  = (COLS_W'(c + 1) == cols_used) ? up_m[0]  : up_r[c+1];
      mid_rc[c] = (COLS_W'(c + 1) == cols_used) ? mid_m[0] : mid_r[c+1];
      dn_rc[c]  = (COLS_W'(c + 1) == cols_used) ? dn_m[0]  : dn_r[c+1];
      nbr[c] = NBR_W'(up_lc[c]) + NBR_W'(up_m[c]) + NBR_W'(up_rc[c])
             + NBR_W'(mid_lc[c]) + NBR_W'(mid_rc[c])
             + NBR_W'(dn_lc[c]) + NBR_W'(dn_m[c]) + NBR_W'(dn_rc[c]);
      new_row[c] = col_mask[c]
                 & ((nbr[c] == BIRTH_COUNT) | (mid_m[c] & (nbr[c] == SURVIVE_COUNT)));
    end
  end

endmodule

[sv/lgs_row_cell.sv]
// ----------------------------------------------------------------------------
// lgs_row_cell
// One link of the row ring: holds one row word, takes a write addressed to
// it, and during a step takes its neighbor's word (or the head word, or the
// freshly computed row, when it is the tail of the rows in use).
// ----------------------------------------------------------------------------
module lgs_row_cell import lgs_pkg::*; #(
  parameter int W     = MAX_COLS_DEF,
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  lgs_cell_ctrl_t   ctrl,
  input  logic [CW-1:0]    rows_used,
  input  logic [SEL_W-1:0] wr_sel,
  input  logic [W-1:0]     wr_data,
  input  logic [W-1:0]     from_next,
  input  logic [W-1:0]     head,
  input  logic [W-1:0]     new_row,
  output logic [W-1:0]     word
);

  logic in_use;
  logic is_tail;
  logic wr_hit;

  assign in_use  = CW'(INDEX) < rows_used;
  assign is_tail = CW'(INDEX + 1) == rows_used;
  assign wr_hit  = ctrl.wr && (32'(wr_sel) == 32'(INDEX));

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (in_use) begin
      if (ctrl.shift) begin
        if (is_tail) begin
          word <= ctrl.run ? new_row : head;
        end else begin
          word <= from_next;
        end
      end else if (wr_hit) begin
        word <= wr_data;
      end
    end
  end

endmodule

[sv/life_grid_generation_step.sv]
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Toroidal Conway life grid (B3/S23), one bit per cell, one word per row.
//
// Requests arrive on cmd: operation 0 writes row_select with row_cells
// (masked to the columns in use, ignored at or beyond the rows in use);
// operation 1 advances one generation. Results leave on res, one new row per
// transfer in row order, last_row set on the final one. cfg writes grid_rows
// (index 0) and grid_cols (index 1) and is always ready. cfg must be used
// only while the block is idle; the block itself does not enforce this.
// The rows sit in a ring of row cells that rotates one place per cycle unless
// res stalls it. A step first turns the ring once over the R rows in use to
// fetch the wrapped upper row, then turns it once more, computing one row per
// cycle while res is not stalled and writing it back at the tail. Row 0 is
// presented on res only after the first turn is complete.
// cmd.ready is high only between steps. A stalled res holds the ring in
// place during the second turn; the final row may wait in the output
// register while new requests are taken. Reset clears the grid to dead
// cells and sets both dimensions to 64.
// ----------------------------------------------------------------------------
module life_grid_generation_step import lgs_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input logic       clk,
  input logic       rst,
  lgs_in_if.sink    cmd,
  lgs_out_if.source res,
  lgs_cfg_if.sink   cfg
);

  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int W  = MAX_COLS;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PRIME = 3'b010,
    ST_RUN   = 3'b100
  } lgs_state_t;

  lgs_state_t       state;
  logic [CW-1:0]    k;
  logic [CFG_W-1:0] grid_rows;
  logic [CFG_W-1:0] grid_cols;
  logic [CW-1:0]    rows_used;
  logic [COLS_W-1:0] cols_used;
  logic [W-1:0]     col_mask;
  logic [W-1:0]     up_row;
  logic [W-1:0]     first_row;
  logic [W-1:0]     cell0;
  logic [W-1:0]     cell1;
  logic [W-1:0]     down_row;
  logic [W-1:0]     new_row;
  logic [W-1:0]     wr_data;
  logic [W-1:0]     cell_word [MAX_ROWS];
  logic             out_valid;
  logic [SEL_W-1:0] out_row_q;
  logic [W-1:0]     out_cells_q;
  logic             out_last;
  logic             k_last;
  logic             adv;
  logic             cmd_acc;
  lgs_cell_ctrl_t   ctrl;

  assign rows_used = (grid_rows == '0) ? CW'(1) :
                     (32'(grid_rows) > 32'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(grid_rows);
  assign cols_used = (grid_cols == '0) ? COLS_W'(1) :
                     (32'(grid_cols) > 32'(MAX_COLS)) ? COLS_W'(MAX_COLS) : COLS_W'(grid_cols);

  always_comb begin
    for (int c = 0; c < W; c++) begin
      col_mask[c] = COLS_W'(c) < cols_used;
    end
  end

  assign cmd_acc = cmd.valid && cmd.ready;
  assign k_last  = k == (rows_used - CW'(1));
  assign adv     = (state == ST_RUN) && (!out_valid || res.ready);
  assign wr_data = cmd.row_cells[W-1:0] & col_mask;

  assign ctrl.shift = (state == ST_PRIME) || adv;
  assign ctrl.run   = state == ST_RUN;
  assign ctrl.wr    = cmd_acc && (cmd.operation == OP_WRITE);

  assign cell0 = cell_word[0];

  generate
    if (MAX_ROWS > 1) begin : g_two
      assign cell1 = cell_word[1];
    end else begin : g_one
      assign cell1 = cell_word[0];
    end

    for (genvar i = 0; i < MAX_ROWS; i++) begin : g_ring
      logic [W-1:0] from_next;
      if (i < MAX_ROWS - 1) begin : g_mid
        assign from_next = cell_word[i+1];
      end else begin : g_end
        assign from_next = cell_word[0];
      end
      lgs_row_cell #(
        .W     (W),
        .CW    (CW),
        .INDEX (i)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .rows_used (rows_used),
        .wr_sel    (cmd.row_select),
        .wr_data   (wr_data),
        .from_next (from_next),
        .head      (cell0),
        .new_row   (new_row),
        .word      (cell_word[i])
      );
    end
  endgenerate

  assign down_row = k_last ? ((k == '0) ? cell0 : first_row) : cell1;

  lgs_rule #(.W(W)) u_rule (
    .up_row    (up_row),
    .mid_row   (cell0),
    .down_row  (down_row),
    .col_mask  (col_mask),
    .cols_used (cols_used),
    .new_row   (new_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
      grid_rows <= GRID_DIM_RESET;
      grid_cols <= GRID_DIM_RESET;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_GRID_ROWS: grid_rows <= cfg.data;
          REG_GRID_COLS: grid_cols <= cfg.data;
          default: ;
        endcase
      end
      if (res.valid && res.ready && !adv) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_acc && (cmd.operation == OP_STEP)) begin
            state <= ST_PRIME;
            k     <= '0;
          end
        end
        ST_PRIME: begin
          if (k_last) begin
            up_row <= cell0;
            k      <= '0;
            state  <= ST_RUN;
          end else begin
            k <= k + CW'(1);
          end
        end
        ST_RUN: begin
          if (adv) begin
            up_row      <= cell0;
            out_valid   <= 1'b1;
            out_row_q   <= SEL_W'(k);
            out_cells_q <= new_row;
            out_last    <= k_last;
            if (k == '0) begin
              first_row <= cell0;
            end
            if (k_last) begin
              k     <= '0;
              state <= ST_IDLE;
            end else begin
              k <= k + CW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign cmd.ready     = state == ST_IDLE;
  assign cfg.ready     = 1'b1;
  assign res.valid     = out_valid;
  assign res.out_row   = out_row_q;
  assign res.out_cells = ROW_W'(out_cells_q);
  assign res.last_row  = out_last;

endmodule

[sv/lgs_checker.sv]
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks for the life grid block, bound to the top level.
// ----------------------------------------------------------------------------
module lgs_checker import lgs_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic             cmd_operation,
  input logic             res_valid,
  input logic             res_ready,
  input logic [SEL_W-1:0] res_out_row,
  input logic [ROW_W-1:0] res_out_cells,
  input logic             res_last_row
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_out_row) && $stable(res_out_cells) && $stable(res_last_row)))
    else $error("result changed while stalled");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && (cmd_operation == OP_STEP)) |=> !cmd_ready)
    else $error("request taken right after a step request");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && (cmd_operation == OP_WRITE)) |=> cmd_ready)
    else $error("row write left the block busy");

  a_mid_step: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_last_row) |-> !cmd_ready)
    else $error("request taken before the generation finished");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .cmd_operation (cmd.operation),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_out_row   (res.out_row),
  .res_out_cells (res.out_cells),
  .res_last_row  (res.last_row)
);

[dv/life_grid_generation_step_test.sv]
// ----------------------------------------------------------------------------
// life_grid_generation_step_test
// Self-checking bench for the toroidal life grid block. A scoreboard keeps
// its own copy of the grid and dimensions and computes every generation
// (B3/S23, wraparound in both directions) as row words. A directed opening
// covers empty grids, full rows, out-of-range writes, masked columns and the
// one-, two-row/column and out-of-range dimensions. Random phases follow,
// each with new dimensions and a mix of row writes and steps. Both sides
// insert random idle and stall bursts, except in the final phases.
// ----------------------------------------------------------------------------
module life_grid_generation_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lgs_pkg::*;

  typedef struct packed {
    logic [SEL_W-1:0] row;
    logic [ROW_W-1:0] cells;
    logic             last;
  } row_result_t;

  class life_grid_scoreboard;
    logic [ROW_W-1:0] grid [MAX_ROWS_DEF];
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    row_result_t      pending_rows [$];
    int               mismatches;

    function new();
      foreach (grid[i]) grid[i] = '0;
      rows_reg   = GRID_DIM_RESET;
      cols_reg   = GRID_DIM_RESET;
      mismatches = 0;
    endfunction

    function int unsigned used_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
      return 32'(rows_reg);
    endfunction

    function int unsigned used_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
      return 32'(cols_reg);
    endfunction

    function logic [ROW_W-1:0] col_mask();
      if (used_cols() >= ROW_W) return '1;
      return (64'd1 << used_cols()) - 64'd1;
    endfunction

    function int pending();
      return pending_rows.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_GRID_ROWS) rows_reg = value;
      else if (idx == REG_GRID_COLS) cols_reg = value;
    endfunction

    function logic [ROW_W-1:0] evolve_row(logic [ROW_W-1:0] up, logic [ROW_W-1:0] mid,
                                          logic [ROW_W-1:0] down, int unsigned cols);
      logic [ROW_W-1:0] nxt;
      int unsigned      left;
      int unsigned      right;
      int unsigned      n;
      nxt = '0;
      for (int unsigned c = 0; c < cols; c++) begin
        left  = (c == 0) ? cols - 1 : c - 1;
        right = (c + 1 >= cols) ? 0 : c + 1;
        n = int'(up[left]) + int'(up[c]) + int'(up[right])
          + int'(mid[left]) + int'(mid[right])
          + int'(down[left]) + int'(down[c]) + int'(down[right]);
        if (n == int'(BIRTH_COUNT) || (mid[c] && n == int'(SURVIVE_COUNT))) nxt[c] = 1'b1;
      end
      return nxt;
    endfunction

    function void note_request(logic op, logic [SEL_W-1:0] sel, logic [ROW_W-1:0] cells);
      logic [ROW_W-1:0] fresh [MAX_ROWS_DEF];
      logic [ROW_W-1:0] mask;
      int unsigned      rows;
      int unsigned      up;
      int unsigned      down;
      row_result_t      res;
      rows = used_rows();
      mask = col_mask();
      if (op == OP_WRITE) begin
        if (sel < rows) grid[sel] = cells & mask;
        return;
      end
      for (int unsigned r = 0; r < rows; r++) begin
        up   = (r == 0) ? rows - 1 : r - 1;
        down = (r + 1 >= rows) ? 0 : r + 1;
        fresh[r] = evolve_row(grid[up] & mask, grid[r] & mask, grid[down] & mask,
                              used_cols()) & mask;
      end
      for (int unsigned r = 0; r < rows; r++) begin
        grid[r]   = fresh[r];
        res.row   = r[SEL_W-1:0];
        res.cells = fresh[r];
        res.last  = (r + 1 == rows);
        pending_rows.push_back(res);
      end
    endfunction

    function void check_row(logic [SEL_W-1:0] row, logic [ROW_W-1:0] cells, logic last);
      row_result_t exp_row;
      if (pending_rows.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected row result: row %0d cells %h last %0b", row, cells, last);
        mismatches++;
        return;
      end
      exp_row = pending_rows.pop_front();
      if (row !== exp_row.row || cells !== exp_row.cells || last !== exp_row.last) begin
        if (mismatches < 10)
          $display("row mismatch: exp row %0d cells %h last %0b, got row %0d cells %h last %0b",
                   exp_row.row, exp_row.cells, exp_row.last, row, cells, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idling;

  life_grid_scoreboard sb;

  lgs_in_if  cmd_ch ();
  lgs_out_if res_ch ();
  lgs_cfg_if cfg_ch ();

  life_grid_generation_step dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_row(res_ch.out_row, res_ch.out_cells, res_ch.last_row);
  end

  task automatic send_request(logic op, logic [SEL_W-1:0] sel, logic [ROW_W-1:0] cells);
    if (idling && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.operation  <= op;
    cmd_ch.row_select <= sel;
    cmd_ch.row_cells  <= cells;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_request(op, sel, cells);
    @(negedge clk);
  endtask

  task automatic write_row(logic [SEL_W-1:0] sel, logic [ROW_W-1:0] cells);
    send_request(OP_WRITE, sel, cells);
  endtask

  task automatic step_grid();
    send_request(OP_STEP, '0, {$urandom, $urandom});
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  // drain all rows, wait, then write the new grid dimensions
  task automatic settle_and_resize(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_GRID_COLS, cols);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [ROW_W-1:0] random_pattern();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd2;
      3:       return 7'd3;
      4:       return 7'd64;
      5:       return 7'd127;
      6:       return CFG_W'($urandom_range(65, 126));
      7:       return CFG_W'($urandom_range(1, 8));
      default: return CFG_W'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    int unsigned rows;
    sb     = new();
    idling = 1'b1;
    rst    = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.operation  = OP_WRITE;
    cmd_ch.row_select = '0;
    cmd_ch.row_cells  = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_GRID_ROWS;
    cfg_ch.data       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    step_grid();
    write_row(6'd0, '1);
    write_row(6'd63, 64'h8000_0000_0000_0001);
    write_row(6'd62, 64'hAAAA_AAAA_AAAA_AAAA);
    write_row(6'd10, 64'h0000_0000_0000_0002);
    write_row(6'd11, 64'h0000_0000_0000_0004);
    write_row(6'd12, 64'h0000_0000_0000_0007);
    step_grid();
    step_grid();

    settle_and_resize(7'd3, 7'd5);
    write_row(6'd3, '1);
    write_row(6'd0, '1);
    write_row(6'd1, 64'hFFFF_0000_0000_0004);
    step_grid();

    settle_and_resize(7'd1, 7'd1);
    write_row(6'd0, 64'h0000_0000_0000_0001);
    write_row(6'd1, '1);
    step_grid();

    settle_and_resize(7'd2, 7'd2);
    write_row(6'd0, 64'h0000_0000_0000_0003);
    write_row(6'd1, 64'h0000_0000_0000_0001);
    step_grid();
    step_grid();

    settle_and_resize(7'd0, 7'd127);
    write_row(6'd0, '1);
    step_grid();

    settle_and_resize(7'd127, 7'd0);
    step_grid();

    for (int phase = 0; phase < 12; phase++) begin
      if (phase >= 10) idling = 1'b0;
      settle_and_resize(random_dim(), random_dim());
      rows = sb.used_rows();
      for (int k = 0; k < 36; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          step_grid();
        end else if ($urandom_range(0, 9) == 0) begin
          write_row(SEL_W'($urandom_range(0, 63)), random_pattern());
        end else begin
          write_row(SEL_W'($urandom_range(0, rows - 1)), random_pattern());
        end
      end
    end

    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[life_grid_generation_step.f]
sv/lgs_pkg.sv
sv/lgs_in_if.sv
sv/lgs_out_if.sv
sv/lgs_cfg_if.sv
sv/lgs_rule.sv
sv/lgs_row_cell.sv
sv/life_grid_generation_step.sv
sv/lgs_checker.sv
dv/life_grid_generation_step_test.sv
